@@ rtl/sfc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and constants of the saturating FIR convolver: item opcodes,
// controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int MAX_TAPS_DEF    = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int TAP_INDEX_W = 8;
  localparam int OP_W        = 2;

  // configuration registers
  localparam int              TAP_COUNT_W   = 9;
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 9'd200;
  localparam int              APB_DATA_W    = 32;
  localparam int              APB_ADDR_W    = 3;
  localparam logic            REG_TAP_COUNT = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic coef_we;     // write tap into coefficient store
    logic push;        // shift a sample into the history
    logic push_zero;   // the shifted sample is zero (tail)
    logic mac_clear;   // restart tap counter and accumulator
    logic issue;       // read one tap pair into the mac pipe
    logic emit;        // load the output register
    logic emit_last;   // result closes the run
    logic clear_hist;  // empty the history after the result
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_issue;  // tap counter sits on the final tap
    logic pipe_busy;   // products still in flight
    logic out_busy;    // output register holds an untaken result
  } dp_status_t;

endpackage

@@ rtl/sfc_stream_if.sv @@
// ----------------------------------------------------------------------------
// sfc_stream_if
// Valid/ready channels of the convolver: the item input and the result
// output, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface sfc_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [7:0]                    tap_index;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          last_sample;

  modport source (output valid, op, tap_index, value, last_sample, input ready);
  modport sink   (input valid, op, tap_index, value, last_sample, output ready);
endinterface

interface sfc_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          last_output;

  modport source (output valid, filtered, last_output, input ready);
  modport sink   (input valid, filtered, last_output, output ready);
endinterface

@@ rtl/sfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfc_ctrl
// Item sequencer: decodes accepted items, keeps the tail count and steps the
// datapath through push, tap walk, pipe drain and result hand-off.
// ----------------------------------------------------------------------------
module sfc_ctrl import sfc_pkg::*; #(
  parameter  int MAX_TAPS = MAX_TAPS_DEF,
  localparam int CNT_W    = $clog2(MAX_TAPS + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [OP_W-1:0]        op_i,
  input  logic [TAP_INDEX_W-1:0] tap_index_i,
  input  logic                   last_sample_i,
  input  logic [CNT_W-1:0]       taps_i,
  input  dp_status_t             status_i,
  output ctrl_cmd_t              cmd_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] tail_q, tail_d;
  logic             last_q, last_d;
  logic             accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tail_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tail_q  <= tail_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d = state_q;
    tail_d  = tail_q;
    last_d  = last_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_LOAD: begin
              cmd_o.coef_we = (int'(tap_index_i) < MAX_TAPS);
            end
            OP_SAMPLE: begin
              cmd_o.push      = 1'b1;
              cmd_o.mac_clear = 1'b1;
              tail_d          = '0;
              last_d          = 1'b0;
              if (last_sample_i) begin
                if (taps_i > CNT_W'(1)) begin
                  tail_d = taps_i - CNT_W'(1);
                end else begin
                  last_d = 1'b1;
                end
              end
              state_d = ST_RUN;
            end
            OP_FLUSH: begin
              // a flush with no tail pending is dropped
              if (tail_q != '0) begin
                cmd_o.push      = 1'b1;
                cmd_o.push_zero = 1'b1;
                cmd_o.mac_clear = 1'b1;
                tail_d          = tail_q - CNT_W'(1);
                last_d          = (tail_q == CNT_W'(1));
                state_d         = ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_last  = last_q;
          cmd_o.clear_hist = last_q;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_tail_drops_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_FLUSH && tail_q != '0) |=> tail_q == $past(tail_q) - CNT_W'(1))
    else $error("tail count did not step down on a flush");

  a_emit_only_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !status_i.pipe_busy)
    else $error("result emitted with products in flight");

  a_push_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> accept && !status_i.pipe_busy)
    else $error("history push outside an accepted item");

endmodule

@@ rtl/sfc_datapath.sv @@
// ----------------------------------------------------------------------------
// sfc_datapath
// Coefficient and history RAMs, circular history pointer with fill count,
// one multiply-accumulate pipe, saturation and the output register.
// ----------------------------------------------------------------------------
module sfc_datapath import sfc_pkg::*; #(
  parameter  int MAX_TAPS    = MAX_TAPS_DEF,
  parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CNT_W       = $clog2(MAX_TAPS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctrl_cmd_t                     cmd_i,
  output dp_status_t                    status_o,
  input  logic [TAP_COUNT_W-1:0]        tap_count_i,
  output logic [CNT_W-1:0]              taps_o,
  input  logic [TAP_INDEX_W-1:0]        tap_index_i,
  input  logic signed [SAMPLE_BITS-1:0] value_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] filtered_o,
  output logic                          last_output_o
);

  localparam int IW     = $clog2(MAX_TAPS);
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + CNT_W;
  localparam int CMP_W  = (CNT_W > TAP_COUNT_W) ? CNT_W : TAP_COUNT_W;
  localparam int FRAC   = SAMPLE_BITS - 1;

  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-FRAC){1'b0}}, {FRAC{1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-FRAC){1'b1}}, {FRAC{1'b0}}};

  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];

  logic [IW-1:0]                 ptr_q, ptr_nxt;
  logic [CNT_W-1:0]              fill_q;
  logic [IW-1:0]                 k_q, tap_last, hist_addr;
  logic [CMP_W-1:0]              tc_ext;
  logic                          rd_vld_q, prod_vld_q;
  logic                          mask_q;
  logic signed [SAMPLE_BITS-1:0] coef_rd_q, hist_rd_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q, acc_shr;
  logic signed [SAMPLE_BITS-1:0] sat_val;
  logic                          out_valid_q, out_last_q;
  logic signed [SAMPLE_BITS-1:0] out_data_q;

  // taps in use, zero taken as one and capped at the store depth
  always_comb begin
    tc_ext = CMP_W'(tap_count_i);
    if (tc_ext == '0) begin
      taps_o = CNT_W'(1);
    end else if (tc_ext > CMP_W'(MAX_TAPS)) begin
      taps_o = CNT_W'(MAX_TAPS);
    end else begin
      taps_o = CNT_W'(tc_ext);
    end
  end

  assign tap_last = IW'(taps_o - CNT_W'(1));
  assign ptr_nxt  = (ptr_q == IW'(MAX_TAPS - 1)) ? '0 : ptr_q + IW'(1);

  // history entry k taps back, wrapping around the circular buffer
  always_comb begin
    if (ptr_q >= k_q) begin
      hist_addr = ptr_q - k_q;
    end else begin
      hist_addr = IW'({1'b0, ptr_q} + (IW+1)'(MAX_TAPS) - {1'b0, k_q});
    end
  end

  // rams: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_we) begin
      coef_mem[IW'(tap_index_i)] <= value_i;
    end
    if (cmd_i.push) begin
      hist_mem[ptr_nxt] <= cmd_i.push_zero ? '0 : value_i;
    end
    if (cmd_i.issue) begin
      coef_rd_q <= coef_mem[k_q];
      hist_rd_q <= hist_mem[hist_addr];
      // entries not written since the last clear read as zero
      mask_q    <= (CNT_W'(k_q) < fill_q);
    end
    if (rd_vld_q) begin
      prod_q <= mask_q ? PROD_W'(coef_rd_q * hist_rd_q) : '0;
    end
    if (cmd_i.mac_clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
    if (cmd_i.emit) begin
      out_data_q <= sat_val;
      out_last_q <= cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      fill_q      <= '0;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_hist) begin
        ptr_q  <= '0;
        fill_q <= '0;
      end else if (cmd_i.push) begin
        ptr_q <= ptr_nxt;
        if (fill_q != CNT_W'(MAX_TAPS)) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
      if (cmd_i.mac_clear) begin
        k_q <= '0;
      end else if (cmd_i.issue) begin
        k_q <= k_q + IW'(1);
      end
      rd_vld_q   <= cmd_i.issue;
      prod_vld_q <= rd_vld_q;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // floor shift back to q1.15, then clip to plus or minus one
  always_comb begin
    acc_shr = acc_q >>> FRAC;
    if (acc_shr > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_BITS-1:0];
    end else if (acc_shr < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_val = acc_shr[SAMPLE_BITS-1:0];
    end
  end

  assign status_o.last_issue = (k_q == tap_last);
  assign status_o.pipe_busy  = rd_vld_q || prod_vld_q;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign filtered_o    = out_data_q;
  assign last_output_o = out_last_q;

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_TAPS))
    else $error("history fill count beyond store depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && !out_ready_i))
    else $error("output register overwritten before transfer");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.emit))
    else $error("result raised without an emit");

endmodule

@@ rtl/saturating_fir_convolver.sv @@
// ----------------------------------------------------------------------------
// saturating_fir_convolver
// Direct form FIR with full linear convolution tail and output saturation.
// ----------------------------------------------------------------------------
// Usage:
//   in_s carries items: op load writes value into coefficient tap_index,
//   op sample shifts value into the history and returns one result, op
//   flush feeds a zero after a sample marked last_sample and returns one
//   tail result. The final tail result has last_output set, after which
//   the history is empty again. With one tap the last sample's own result
//   is marked last. Flush with no tail pending and op 3 give no result.
//   out_m carries filtered (q1.15, clipped to plus or minus one).
//   The tap_count register (APB, byte address 0) sets the taps in use.
// Timing:
//   a load or dropped item leaves the block idle and ready again. A
//   sample or flush runs push, tap walk, pipe drain and hand-off: one
//   shared multiplier walks one tap a cycle over the single read port of
//   each ram. The next item is taken as soon as the result sits in the
//   output register.
// Reset: tap_count returns to 200 and the history is empty; coefficients
//   hold nothing until loaded. A stalled receiver holds the result, and
//   the block then holds off the next result, not the next transfer.
// ----------------------------------------------------------------------------
module saturating_fir_convolver import sfc_pkg::*; #(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfc_in_if.sink                in_s,
  sfc_out_if.source             out_m,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  logic [TAP_COUNT_W-1:0] tap_count_q;
  logic [CNT_W-1:0]       taps;
  ctrl_cmd_t              cmd;
  dp_status_t             status;
  logic                   reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TAP_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      tap_count_q <= pwdata[TAP_COUNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(tap_count_q) : '0;

  sfc_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_s.valid),
    .in_ready_o    (in_s.ready),
    .op_i          (in_s.op),
    .tap_index_i   (in_s.tap_index),
    .last_sample_i (in_s.last_sample),
    .taps_i        (taps),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  sfc_datapath #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .tap_count_i   (tap_count_q),
    .taps_o        (taps),
    .tap_index_i   (in_s.tap_index),
    .value_i       (in_s.value),
    .out_ready_i   (out_m.ready),
    .out_valid_o   (out_m.valid),
    .filtered_o    (out_m.filtered),
    .last_output_o (out_m.last_output)
  );

endmodule

@@ sim/saturating_fir_convolver_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// saturating_fir_convolver_tb
// Self-checking bench for the saturating FIR convolver. The whole coefficient
// store is loaded first. A directed stream then covers saturation, tails and
// dropped items, followed by random streams over a range of tap counts. Every
// accepted item runs through a local convolution model, and each output
// transfer is checked against the oldest predicted result.
// ----------------------------------------------------------------------------
module saturating_fir_convolver_tb;
  import sfc_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int MAX_TAPS     = MAX_TAPS_DEF;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int SETTLE       = 16;
  localparam int NUM_PHASES   = 12;

  localparam logic [OP_W-1:0]       OP_UNDEF       = 2'd3;
  localparam logic [APB_ADDR_W-1:0] TAP_COUNT_ADDR = APB_ADDR_W'(4 * int'(REG_TAP_COUNT));

  localparam int PHASE_TAPS [NUM_PHASES] = '{3, 8, 2, 16, 1, 256, 40, 511, 5, 0, 24, 200};
  localparam int PHASE_ITEMS[NUM_PHASES] = '{25, 20, 20, 20, 20, 15, 15, 10, 20, 15, 25, 15};

  typedef struct {
    logic [OP_W-1:0]        op;
    logic [TAP_INDEX_W-1:0] tap_index;
    logic signed [SB-1:0]   value;
    logic                   last_sample;
  } conv_item_t;

  typedef struct {
    logic signed [SB-1:0] filtered;
    logic                 last_output;
  } conv_result_t;

  logic clk_i;
  logic rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sfc_in_if  #(.SAMPLE_BITS(SB)) in_if ();
  sfc_out_if #(.SAMPLE_BITS(SB)) out_if ();

  saturating_fir_convolver #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SB)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (in_if),
    .out_m  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // convolution model state
  logic signed [SB-1:0]   coef_mem[MAX_TAPS];
  logic signed [SB-1:0]   hist[MAX_TAPS];
  logic [7:0]             hist_ptr;
  int                     tail_left;
  logic [TAP_COUNT_W-1:0] taps_cfg;

  conv_item_t   pending_items[$];
  conv_result_t expected_outputs[$];
  conv_item_t   drive_item;

  int items_pushed;
  int items_taken;
  int gen_taps;
  int gen_tail;
  int burst_left;
  int gap_left;
  int ready_pct;
  int ready_win;
  int cycle_cnt;
  bit failed;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int active_taps();
    if (taps_cfg == 0) return 1;
    if (taps_cfg > MAX_TAPS) return MAX_TAPS;
    return int'(taps_cfg);
  endfunction

  function automatic void clear_history();
    foreach (hist[i]) hist[i] = '0;
    hist_ptr = '0;
  endfunction

  function automatic void shift_in(input logic signed [SB-1:0] x);
    hist_ptr       = hist_ptr + 8'd1;
    hist[hist_ptr] = x;
  endfunction

  // exact sum of products, floor shift to q1.15, clip to plus or minus one
  function automatic logic signed [SB-1:0] conv_output();
    longint acc;
    longint q;
    int     n;
    int     k;
    logic [7:0] pos;
    acc = 0;
    n   = active_taps();
    for (k = 0; k < n; k++) begin
      pos = hist_ptr - 8'(k);
      acc += longint'(coef_mem[k]) * longint'(hist[pos]);
    end
    q = acc >>> (SB - 1);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return SB'(q);
  endfunction

  task automatic convolve_step(input conv_item_t it);
    conv_result_t res;
    bit           emit;
    emit            = 1'b0;
    res.last_output = 1'b0;
    res.filtered    = '0;
    case (it.op)
      OP_LOAD: begin
        coef_mem[it.tap_index] = it.value;
      end
      OP_SAMPLE: begin
        tail_left = 0;
        shift_in(it.value);
        res.filtered = conv_output();
        emit         = 1'b1;
        if (it.last_sample) begin
          if (active_taps() > 1) begin
            tail_left = active_taps() - 1;
          end else begin
            res.last_output = 1'b1;
            clear_history();
          end
        end
      end
      OP_FLUSH: begin
        if (tail_left > 0) begin
          shift_in('0);
          res.filtered = conv_output();
          emit         = 1'b1;
          tail_left--;
          if (tail_left == 0) begin
            res.last_output = 1'b1;
            clear_history();
          end
        end
      end
      default: ;
    endcase
    if (emit) expected_outputs.insert(expected_outputs.size(), res);
  endtask

  // item driver: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        convolve_step(drive_item);
        items_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          drive_item        = pending_items.pop_front();
          in_if.valid       <= 1'b1;
          in_if.op          <= drive_item.op;
          in_if.tap_index   <= drive_item.tap_index;
          in_if.value       <= drive_item.value;
          in_if.last_sample <= drive_item.last_sample;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              7:       gap_left = $urandom_range(20, 40);
              default: gap_left = $urandom_range(1, 10);
            endcase
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor, with a ready rate that changes from window to window
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected result: filtered %0d last_output %0b",
                 out_if.filtered, out_if.last_output);
          failed = 1'b1;
        end else begin
          conv_result_t exp_res;
          exp_res = expected_outputs.pop_front();
          if (out_if.filtered !== exp_res.filtered) begin
            $error("filtered: expected %0d, got %0d", exp_res.filtered, out_if.filtered);
            failed = 1'b1;
          end
          if (out_if.last_output !== exp_res.last_output) begin
            $error("last_output: expected %0b, got %0b",
                   exp_res.last_output, out_if.last_output);
            failed = 1'b1;
          end
        end
      end
      if (ready_win > 0) begin
        ready_win--;
      end else begin
        ready_win = $urandom_range(32, 300);
        case ($urandom_range(0, 4))
          0, 1:    ready_pct = 100;
          2:       ready_pct = 75;
          3:       ready_pct = 30;
          default: ready_pct = 5;
        endcase
      end
      out_if.ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [SB-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return $urandom_range(0, 1) ? 16'sh0000 : 16'shffff;
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic [OP_W-1:0] op, input logic [TAP_INDEX_W-1:0] idx,
                            input logic signed [SB-1:0] val, input logic last);
    conv_item_t it;
    it.op          = op;
    it.tap_index   = idx;
    it.value       = val;
    it.last_sample = last;
    pending_items.insert(pending_items.size(), it);
    items_pushed++;
    // rough view of the tail, only used to shape the stimulus
    if (op == OP_SAMPLE) gen_tail = last ? gen_taps - 1 : 0;
    else if (op == OP_FLUSH && gen_tail > 0) gen_tail--;
  endtask

  task automatic wait_drained();
    while (items_taken != items_pushed || expected_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_taps(input logic [TAP_COUNT_W-1:0] v);
    wait_drained();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TAP_COUNT_ADDR;
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    taps_cfg = v;
    gen_taps = active_taps();
  endtask

  // mostly complete streams with their tails, some cut short, plus noise
  task automatic random_runs(input int n_items);
    int start;
    int r;
    int len;
    int nflush;
    int i;
    start = items_pushed;
    while (items_pushed - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        queue_item(OP_LOAD, TAP_INDEX_W'($urandom), pick_value(), 1'($urandom));
      end else if (r < 8) begin
        queue_item(OP_UNDEF, TAP_INDEX_W'($urandom), pick_value(), 1'($urandom));
      end else if (r < 10) begin
        queue_item(OP_FLUSH, TAP_INDEX_W'($urandom), pick_value(), 1'($urandom));
      end else begin
        len = $urandom_range(1, 10);
        for (i = 0; i < len; i++)
          queue_item(OP_SAMPLE, TAP_INDEX_W'($urandom), pick_value(), i == len - 1);
        r = $urandom_range(0, 99);
        if (gen_tail > 40) nflush = $urandom_range(0, 6);
        else if (r < 12) nflush = $urandom_range(0, gen_tail);
        else if (r < 20) nflush = gen_tail + 1;
        else nflush = gen_tail;
        for (i = 0; i < nflush; i++)
          queue_item(OP_FLUSH, TAP_INDEX_W'($urandom), pick_value(), 1'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int i;
    int p;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.op          = OP_LOAD;
    in_if.tap_index   = '0;
    in_if.value       = '0;
    in_if.last_sample = 1'b0;
    out_if.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    foreach (coef_mem[k]) coef_mem[k] = '0;
    clear_history();
    tail_left    = 0;
    taps_cfg     = TAP_COUNT_RST;
    items_pushed = 0;
    items_taken  = 0;
    gen_taps     = active_taps();
    gen_tail     = 0;
    burst_left   = 8;
    gap_left     = 0;
    ready_pct    = 100;
    ready_win    = 0;
    cycle_cnt    = 0;
    failed       = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill the whole store so no sample ever reads an empty tap
    for (i = 0; i < MAX_TAPS; i++)
      queue_item(OP_LOAD, TAP_INDEX_W'(i), pick_value(), 1'($urandom));
    // a short stream on the reset tap count
    for (i = 0; i < 5; i++) queue_item(OP_SAMPLE, 8'd0, pick_value(), 1'b0);

    // saturation at both rails, tail dropped by a sample, stray flushes
    set_taps(4);
    queue_item(OP_LOAD,   8'd0,   16'sh8000, 1'b0);
    queue_item(OP_LOAD,   8'd1,   16'sh7fff, 1'b1);
    queue_item(OP_LOAD,   8'd2,   16'sh8000, 1'b0);
    queue_item(OP_LOAD,   8'd3,   16'sh7fff, 1'b0);
    queue_item(OP_LOAD,   8'd255, 16'sh7fff, 1'b0);
    queue_item(OP_FLUSH,  8'd0,   16'sh0000, 1'b0);
    queue_item(OP_UNDEF,  8'hff,  16'shffff, 1'b1);
    queue_item(OP_SAMPLE, 8'd0,   16'sh8000, 1'b0);
    queue_item(OP_SAMPLE, 8'd0,   16'sh8000, 1'b0);
    queue_item(OP_SAMPLE, 8'd0,   16'sh7fff, 1'b0);
    queue_item(OP_SAMPLE, 8'd0,   16'sh7fff, 1'b1);
    queue_item(OP_FLUSH,  8'd0,   16'sh0000, 1'b0);
    queue_item(OP_SAMPLE, 8'd0,   16'sh0000, 1'b0);
    queue_item(OP_SAMPLE, 8'd0,   16'shffff, 1'b1);
    for (i = 0; i < 4; i++) queue_item(OP_FLUSH, 8'd0, 16'sh0000, 1'b0);

    // single tap kernel: the last sample closes the run itself
    set_taps(1);
    queue_item(OP_SAMPLE, 8'd0, 16'sh7fff, 1'b1);
    queue_item(OP_SAMPLE, 8'd0, 16'sh8000, 1'b0);
    queue_item(OP_SAMPLE, 8'd0, 16'sh0001, 1'b1);

    // tap count changed in the middle of a tail
    set_taps(6);
    for (i = 0; i < 3; i++) queue_item(OP_SAMPLE, 8'd0, pick_value(), i == 2);
    queue_item(OP_FLUSH, 8'd0, 16'sh0000, 1'b0);
    queue_item(OP_FLUSH, 8'd0, 16'sh0000, 1'b0);
    set_taps(3);
    for (i = 0; i < 4; i++) queue_item(OP_FLUSH, 8'd0, 16'sh0000, 1'b0);

    // zero tap count acts as one
    set_taps(0);
    queue_item(OP_SAMPLE, 8'd0, 16'sh8000, 1'b1);
    queue_item(OP_SAMPLE, 8'd0, 16'sh4000, 1'b0);

    for (p = 0; p < NUM_PHASES; p++) begin
      set_taps(TAP_COUNT_W'(PHASE_TAPS[p]));
      random_runs(PHASE_ITEMS[p]);
    end

    wait_drained();
    if (!failed && expected_outputs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
